// ===== sv/hsvw_pkg.sv =====
// Shared types and constants for the HSV to RGBW converter pipeline.
// No dependencies; imported by every module of the converter.
package hsvw_pkg;

  localparam logic [8:0] HUE_MAX    = 9'd359;
  localparam logic [8:0] SECTOR_DEG = 9'd60;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam int unsigned PROD_SHIFT = 8;

  localparam logic [8:0] SEC1_BASE = SECTOR_DEG;
  localparam logic [8:0] SEC2_BASE = 9'(2 * SECTOR_DEG);
  localparam logic [8:0] SEC3_BASE = 9'(3 * SECTOR_DEG);
  localparam logic [8:0] SEC4_BASE = 9'(4 * SECTOR_DEG);
  localparam logic [8:0] SEC5_BASE = 9'(5 * SECTOR_DEG);

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } rgbw_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic       gray;
  } sec_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [7:0] val;
    logic       gray;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } pqt_t;

endpackage

// ===== sv/hsv_to_rgbw_converter_unit.sv =====
// HSV to RGBW converter: one color in, four 8-bit LED channels out.
// Depends on hsvw_pkg, hsvw_sector, hsvw_product and hsvw_mix.
//
// Accepts one hue/saturation/value color per clock cycle while in_stall is low, and
// returns red, green, blue and white through five register stages, one each for the
// sector split, the p product with the scaled remainders, the q and t products,
// the sector multiplexer with the minimum search, and the white extraction. Each
// stage loads whenever it is empty or its successor moves, so a stall on the
// result channel fills empty stages first and raises in_stall only when all five
// stages hold a color. Hues above 359 are treated as 359; zero saturation gives
// white at the value level with the three color channels at zero.
module hsv_to_rgbw_converter_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hsvw_pkg::hsv_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hsvw_pkg::rgbw_t out_data
);
  import hsvw_pkg::*;

  logic  s1_rdy;
  logic  s1_vld;
  sec_t  s1_data;
  logic  prd_rdy;
  logic  s3_vld;
  pqt_t  s3_data;
  logic  mix_rdy;

  hsvw_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_rdy  (s1_rdy),
    .up_data (in_data),
    .dn_vld  (s1_vld),
    .dn_rdy  (prd_rdy),
    .dn_data (s1_data)
  );

  hsvw_product u_product (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (s1_vld),
    .up_rdy  (prd_rdy),
    .up_data (s1_data),
    .dn_vld  (s3_vld),
    .dn_rdy  (mix_rdy),
    .dn_data (s3_data)
  );

  hsvw_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (s3_vld),
    .up_rdy  (mix_rdy),
    .up_data (s3_data),
    .dn_vld  (out_valid),
    .dn_rdy  (!out_stall),
    .dn_data (out_data)
  );

  assign in_stall = !s1_rdy;

  a_in_open_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output stage");

  a_color_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red == 8'd0 || out_data.green == 8'd0 ||
                   out_data.blue == 8'd0))
    else $error("white extraction left all three colors nonzero");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld |-> (s1_data.sector <= SEC_5))
    else $error("sector out of range");

  a_out_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// ===== sv/hsvw_sector.sv =====
// Stage 1: hue clamp, sector split and scaled remainder within the sector.
// Depends on hsvw_pkg.
module hsvw_sector (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_vld,
  output logic          up_rdy,
  input  hsvw_pkg::hsv_t up_data,
  output logic          dn_vld,
  input  logic          dn_rdy,
  output hsvw_pkg::sec_t dn_data
);
  import hsvw_pkg::*;

  logic       vld_r;
  sec_t       data_r;
  sec_t       data_nxt;
  logic [8:0] hue_c;
  logic [8:0] base;
  logic [2:0] sec;
  logic [5:0] rem;
  logic [9:0] rem17;

  always_comb begin
    hue_c = (up_data.hue > HUE_MAX) ? HUE_MAX : up_data.hue;
    if (hue_c >= SEC5_BASE) begin
      sec = SEC_5; base = SEC5_BASE;
    end else if (hue_c >= SEC4_BASE) begin
      sec = SEC_4; base = SEC4_BASE;
    end else if (hue_c >= SEC3_BASE) begin
      sec = SEC_3; base = SEC3_BASE;
    end else if (hue_c >= SEC2_BASE) begin
      sec = SEC_2; base = SEC2_BASE;
    end else if (hue_c >= SEC1_BASE) begin
      sec = SEC_1; base = SEC1_BASE;
    end else begin
      sec = SEC_0; base = 9'd0;
    end
    rem   = 6'(hue_c - base);
    // rem * 255 / 60 == rem * 17 / 4
    rem17 = {rem, 4'b0000} + {4'b0000, rem};
    data_nxt.sector = sec;
    data_nxt.frac   = rem17[9:2];
    data_nxt.sat    = up_data.saturation;
    data_nxt.val    = up_data.value;
    data_nxt.gray   = (up_data.saturation == 8'd0);
  end

  assign up_rdy  = !vld_r || dn_rdy;
  assign dn_vld  = vld_r;
  assign dn_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/hsvw_product.sv =====
// Stages 2 and 3: the p product with the saturation-scaled remainders, then q and t.
// Depends on hsvw_pkg.
module hsvw_product (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_vld,
  output logic           up_rdy,
  input  hsvw_pkg::sec_t up_data,
  output logic           dn_vld,
  input  logic           dn_rdy,
  output hsvw_pkg::pqt_t dn_data
);
  import hsvw_pkg::*;

  logic        s2_vld_r;
  logic        s2_rdy;
  logic [2:0]  s2_sector_r;
  logic [7:0]  s2_val_r;
  logic        s2_gray_r;
  logic [7:0]  s2_p_r;
  logic [7:0]  s2_sf_r;
  logic [7:0]  s2_sg_r;
  logic [15:0] p_prod;
  logic [15:0] sf_prod;
  logic [15:0] sg_prod;

  logic        s3_vld_r;
  logic        s3_rdy;
  pqt_t        s3_data_r;
  pqt_t        s3_data_nxt;
  logic [15:0] q_prod;
  logic [15:0] t_prod;

  always_comb begin
    p_prod  = {8'd0, up_data.val} * {8'd0, FULL_SCALE - up_data.sat};
    sf_prod = {8'd0, up_data.sat} * {8'd0, up_data.frac};
    sg_prod = {8'd0, up_data.sat} * {8'd0, FULL_SCALE - up_data.frac};
  end

  assign s2_rdy = !s2_vld_r || s3_rdy;
  assign up_rdy = s2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && up_vld) begin
      s2_sector_r <= up_data.sector;
      s2_val_r    <= up_data.val;
      s2_gray_r   <= up_data.gray;
      s2_p_r      <= 8'(p_prod >> PROD_SHIFT);
      s2_sf_r     <= 8'(sf_prod >> PROD_SHIFT);
      s2_sg_r     <= 8'(sg_prod >> PROD_SHIFT);
    end
  end

  always_comb begin
    q_prod = {8'd0, s2_val_r} * {8'd0, FULL_SCALE - s2_sf_r};
    t_prod = {8'd0, s2_val_r} * {8'd0, FULL_SCALE - s2_sg_r};
    s3_data_nxt.sector = s2_sector_r;
    s3_data_nxt.val    = s2_val_r;
    s3_data_nxt.gray   = s2_gray_r;
    s3_data_nxt.p      = s2_p_r;
    s3_data_nxt.q      = 8'(q_prod >> PROD_SHIFT);
    s3_data_nxt.t      = 8'(t_prod >> PROD_SHIFT);
  end

  assign s3_rdy  = !s3_vld_r || dn_rdy;
  assign dn_vld  = s3_vld_r;
  assign dn_data = s3_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      s3_data_r <= s3_data_nxt;
    end
  end

endmodule

// ===== sv/hsvw_mix.sv =====
// Stages 4 and 5: sector multiplexer with minimum search, then white extraction.
// Depends on hsvw_pkg.
module hsvw_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_vld,
  output logic            up_rdy,
  input  hsvw_pkg::pqt_t  up_data,
  output logic            dn_vld,
  input  logic            dn_rdy,
  output hsvw_pkg::rgbw_t dn_data
);
  import hsvw_pkg::*;

  logic       s4_vld_r;
  logic       s4_rdy;
  rgbw_t      s4_data_r;
  rgbw_t      s4_data_nxt;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] m;

  logic       s5_vld_r;
  logic       s5_rdy;
  rgbw_t      s5_data_r;
  rgbw_t      s5_data_nxt;

  always_comb begin
    case (up_data.sector)
      SEC_0: begin
        r = up_data.val; g = up_data.t;   b = up_data.p;
      end
      SEC_1: begin
        r = up_data.q;   g = up_data.val; b = up_data.p;
      end
      SEC_2: begin
        r = up_data.p;   g = up_data.val; b = up_data.t;
      end
      SEC_3: begin
        r = up_data.p;   g = up_data.q;   b = up_data.val;
      end
      SEC_4: begin
        r = up_data.t;   g = up_data.p;   b = up_data.val;
      end
      default: begin
        r = up_data.val; g = up_data.p;   b = up_data.q;
      end
    endcase
    // gray: all three at value, so extraction leaves only white
    if (up_data.gray) begin
      r = up_data.val; g = up_data.val; b = up_data.val;
    end
    m = (r < g) ? r : g;
    m = (m < b) ? m : b;
    s4_data_nxt.red   = r;
    s4_data_nxt.green = g;
    s4_data_nxt.blue  = b;
    s4_data_nxt.white = m;
  end

  assign s4_rdy = !s4_vld_r || s5_rdy;
  assign up_rdy = s4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && up_vld) begin
      s4_data_r <= s4_data_nxt;
    end
  end

  always_comb begin
    s5_data_nxt.red   = s4_data_r.red   - s4_data_r.white;
    s5_data_nxt.green = s4_data_r.green - s4_data_r.white;
    s5_data_nxt.blue  = s4_data_r.blue  - s4_data_r.white;
    s5_data_nxt.white = s4_data_r.white;
  end

  assign s5_rdy  = !s5_vld_r || dn_rdy;
  assign dn_vld  = s5_vld_r;
  assign dn_data = s5_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && s4_vld_r) begin
      s5_data_r <= s5_data_nxt;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for hsv_to_rgbw_converter_unit.
// Depends on hsvw_pkg and the converter RTL: a queue-fed driver with random gaps,
// a monitor with random stalls, and an in-line RGBW predictor.
`timescale 1ns / 100ps

module tb;
  import hsvw_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_COLORS = 1900;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 250;

  typedef struct {
    hsv_t color;
    bit   wait_idle;
  } color_job_t;

  typedef struct {
    hsv_t  color;
    rgbw_t rgbw;
  } rgbw_expect_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  hsv_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  rgbw_t out_data;

  color_job_t   pending_colors[$];
  rgbw_expect_t expected_rgbw[$];

  int error_count = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int tx_gap_left = 0;
  int tx_quiet_left = 0;
  bit tx_quiet = 1'b0;
  int rx_stall_left = 0;
  int rx_quiet_left = 0;
  bit rx_quiet = 1'b0;
  bit long_hold_done = 1'b0;

  hsv_to_rgbw_converter_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rgbw_t predict_rgbw(hsv_t c);
    int unsigned h, s, v, sec, frac, p, q, t, r, g, b, w;
    rgbw_t res;
    h = c.hue;
    s = c.saturation;
    v = c.value;
    if (h > HUE_MAX) h = HUE_MAX;
    if (s == 0) begin
      r = 0;
      g = 0;
      b = 0;
      w = v;
    end else begin
      sec = h / SECTOR_DEG;
      frac = ((h - sec * SECTOR_DEG) * FULL_SCALE) / SECTOR_DEG;
      p = (v * (FULL_SCALE - s)) >> PROD_SHIFT;
      q = (v * (FULL_SCALE - ((s * frac) >> PROD_SHIFT))) >> PROD_SHIFT;
      t = (v * (FULL_SCALE - ((s * (FULL_SCALE - frac)) >> PROD_SHIFT))) >> PROD_SHIFT;
      case (3'(sec))
        SEC_0: begin r = v; g = t; b = p; end
        SEC_1: begin r = q; g = v; b = p; end
        SEC_2: begin r = p; g = v; b = t; end
        SEC_3: begin r = p; g = q; b = v; end
        SEC_4: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
      w = (r < g) ? r : g;
      if (b < w) w = b;
      r -= w;
      g -= w;
      b -= w;
    end
    res.red = 8'(r);
    res.green = 8'(g);
    res.blue = 8'(b);
    res.white = 8'(w);
    return res;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_color(int h, int s, int v, bit wait_idle);
    color_job_t job;
    job.color.hue = 9'(h);
    job.color.saturation = 8'(s);
    job.color.value = 8'(v);
    job.wait_idle = wait_idle;
    pending_colors.push_back(job);
  endtask

  // driver
  always @(posedge clk) begin
    color_job_t job;
    bit load;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      load = 1'b0;
      if (in_valid && !in_stall)
        expected_rgbw.push_back('{color: in_data, rgbw: predict_rgbw(in_data)});
      if (tx_quiet_left == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        tx_quiet_left = $urandom_range(30, 150);
      end else begin
        tx_quiet_left--;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (pending_colors.size() != 0) begin
          job = pending_colors[0];
          if (!job.wait_idle || expected_rgbw.size() == 0) begin
            void'(pending_colors.pop_front());
            in_data <= job.color;
            load = 1'b1;
            tx_gap_left = pick_gap(tx_quiet);
          end
        end
        in_valid <= load;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgbw_expect_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_rgbw.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected transfer: r=%0d g=%0d b=%0d w=%0d", out_data.red,
                     out_data.green, out_data.blue, out_data.white);
        end else begin
          want = expected_rgbw.pop_front();
          if (out_data.red !== want.rgbw.red || out_data.green !== want.rgbw.green ||
              out_data.blue !== want.rgbw.blue || out_data.white !== want.rgbw.white) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch h=%0d s=%0d v=%0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.color.hue, want.color.saturation, want.color.value,
                       want.rgbw.red, want.rgbw.green, want.rgbw.blue, want.rgbw.white,
                       out_data.red, out_data.green, out_data.blue, out_data.white);
          end
        end
      end
      if (rx_quiet_left == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet_left = $urandom_range(30, 150);
      end else begin
        rx_quiet_left--;
      end
      // hold off long enough to fill the pipeline and back up the input
      if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_stall_left = LONG_HOLD_CYCLES;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_stall_left = pick_gap(rx_quiet);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int h, s, v, roll;
    add_color(0, 255, 255, 1'b0);
    add_color(59, 255, 255, 1'b0);
    add_color(60, 255, 255, 1'b0);
    add_color(119, 255, 255, 1'b0);
    add_color(120, 255, 255, 1'b0);
    add_color(179, 255, 255, 1'b0);
    add_color(180, 255, 255, 1'b0);
    add_color(239, 255, 255, 1'b0);
    add_color(240, 255, 255, 1'b0);
    add_color(299, 255, 255, 1'b0);
    add_color(300, 255, 255, 1'b0);
    add_color(359, 255, 255, 1'b0);
    add_color(360, 255, 255, 1'b0);
    add_color(511, 255, 255, 1'b0);
    add_color(256, 128, 200, 1'b0);
    add_color(0, 0, 255, 1'b0);
    add_color(200, 0, 0, 1'b0);
    add_color(511, 0, 170, 1'b0);
    add_color(30, 1, 1, 1'b0);
    add_color(90, 255, 0, 1'b0);
    add_color(150, 128, 200, 1'b0);
    add_color(210, 85, 170, 1'b0);
    add_color(270, 200, 100, 1'b0);
    add_color(330, 64, 255, 1'b0);
    for (int i = 0; i < RANDOM_COLORS; i++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) h = $urandom_range(360, 511);
      else if (roll == 1) h = 60 * $urandom_range(0, 5) + $urandom_range(0, 1) * 59;
      else h = $urandom_range(0, 359);
      roll = $urandom_range(0, 19);
      if (roll < 2) s = 0;
      else if (roll < 4) s = 255;
      else if (roll == 4) s = 1;
      else s = $urandom_range(0, 255);
      roll = $urandom_range(0, 19);
      if (roll < 2) v = 0;
      else if (roll < 4) v = 255;
      else v = $urandom_range(0, 255);
      // drain the pipeline before the first random color and once midway
      add_color(h, s, v, (i == 0) || (i == RANDOM_COLORS / 2));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_colors.size() != 0 || in_valid || expected_rgbw.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hsvw_pkg.sv
sv/hsvw_sector.sv
sv/hsvw_product.sv
sv/hsvw_mix.sv
sv/hsv_to_rgbw_converter_unit.sv
sim/tb.sv
